// ===== hdl/tfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types and codes for the trigger frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package tfd_pkg;

  // result field codes
  typedef enum logic [3:0] {
    KIND_META   = 4'd0,
    KIND_SIZE   = 4'd1,
    KIND_SOURCE = 4'd2,
    KIND_FTYPE  = 4'd3,
    KIND_REV    = 4'd4,
    KIND_COINC  = 4'd5,
    KIND_TRIG   = 4'd6,
    KIND_TIME   = 4'd7,
    KIND_WINDOW = 4'd8,
    KIND_COUNT  = 4'd9,
    KIND_RESET  = 4'd10,
    KIND_END    = 4'd11
  } field_kind_t;

  localparam int HEADER_LEN  = 9;   // header plus coincidence byte
  localparam int TIME_BYTES  = 6;
  localparam int WIN_BYTES   = 2;
  localparam int CNT_BYTES   = 3;
  localparam int RST_BYTES   = 3;
  localparam int UNUSED_LEN  = 20;
  localparam int POS_W       = 24;
  localparam int VALUE_W     = 48;

  // decode of one byte offset within the frame layout
  typedef struct packed {
    logic        hit;    // offset belongs to a decoded field
    logic        done;   // last byte of that field
    field_kind_t kind;
    logic [3:0]  idx;    // detector number
  } layout_dec_t;

endpackage

`default_nettype wire

// ===== hdl/tfd_layout.sv =====
// ----------------------------------------------------------------------------
// tfd_layout
// Maps a byte offset within a trigger frame to the field it belongs to.
// ----------------------------------------------------------------------------
`default_nettype none

module tfd_layout #(
  parameter int DETECTORS = 4
) (
  input  wire logic [tfd_pkg::POS_W-1:0] pos,
  output tfd_pkg::layout_dec_t           dec
);
  import tfd_pkg::*;

  localparam int TIME_AT   = HEADER_LEN + DETECTORS;
  localparam int WIN_AT    = TIME_AT + TIME_BYTES;
  localparam int CNT_AT    = WIN_AT + WIN_BYTES;
  localparam int RST_AT    = CNT_AT + CNT_BYTES * DETECTORS;
  localparam int UNUSED_AT = RST_AT + RST_BYTES;

  // offset into the count block, below 48
  logic [6:0]  cnt_off;
  logic [12:0] cnt_prod;
  logic [3:0]  cnt_det;
  logic [6:0]  cnt_rem;

  assign cnt_off  = 7'(pos - POS_W'(CNT_AT));
  // divide by three via reciprocal, exact for offsets below 48 (4-bit quotient)
  assign cnt_prod = 13'(cnt_off) * 13'd43;
  assign cnt_det  = cnt_prod[10:7];
  assign cnt_rem  = cnt_off - 7'(cnt_det) * 7'd3;

  always_comb begin
    dec.hit  = 1'b1;
    dec.done = 1'b1;
    dec.idx  = '0;
    dec.kind = KIND_META;
    if (pos == POS_W'(0)) begin
      dec.kind = KIND_META;
    end else if (pos <= POS_W'(3)) begin
      dec.kind = KIND_SIZE;
      dec.done = (pos == POS_W'(3));
    end else if (pos == POS_W'(4)) begin
      dec.kind = KIND_SOURCE;
    end else if (pos <= POS_W'(6)) begin
      dec.kind = KIND_FTYPE;
      dec.done = (pos == POS_W'(6));
    end else if (pos == POS_W'(7)) begin
      dec.kind = KIND_REV;
    end else if (pos == POS_W'(8)) begin
      dec.kind = KIND_COINC;
    end else if (pos < POS_W'(TIME_AT)) begin
      dec.kind = KIND_TRIG;
      dec.idx  = 4'(pos - POS_W'(HEADER_LEN));
    end else if (pos < POS_W'(WIN_AT)) begin
      dec.kind = KIND_TIME;
      dec.done = (pos == POS_W'(WIN_AT - 1));
    end else if (pos < POS_W'(CNT_AT)) begin
      dec.kind = KIND_WINDOW;
      dec.done = (pos == POS_W'(CNT_AT - 1));
    end else if (pos < POS_W'(RST_AT)) begin
      dec.kind = KIND_COUNT;
      dec.idx  = cnt_det;
      dec.done = (cnt_rem == 7'd2);
    end else if (pos < POS_W'(UNUSED_AT)) begin
      dec.kind = KIND_RESET;
      dec.done = (pos == POS_W'(UNUSED_AT - 1));
    end else begin
      dec.hit  = 1'b0;
      dec.done = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/trigger_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// trigger_frame_deframer
// Decodes a byte stream of back-to-back trigger frames into field results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel data_valid/data_stall carries one stream byte per
//   transaction. Output channel result_valid/result_stall carries one decoded
//   field per transaction: kind, detector index, big-endian value, and on the
//   frame-end result the short-frame and last-of-frame flags.
//   A byte is taken into an input register, decoded against the frame layout
//   and written to the result register when the output can advance. One byte
//   is processed per cycle unless a stalled result holds the flow; the
//   position counter and shift accumulator update together as it is taken.
//   Bytes that close no field produce no transaction on the output.
//   While result_stall holds a pending result, the input register keeps its
//   byte and data_stall rises once it is full.
//   Reset clears the frame position, declared size, accumulator and both
//   valid flags; the next byte is taken as the first byte of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module trigger_frame_deframer #(
  parameter int DETECTORS = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            data_valid,
  output      logic                            data_stall,
  input  wire logic [7:0]                      data_byte,
  output      logic                            result_valid,
  input  wire logic                            result_stall,
  output      logic [3:0]                      field_kind,
  output      logic [3:0]                      detector_index,
  output      logic [tfd_pkg::VALUE_W-1:0]     field_value,
  output      logic                            short_frame,
  output      logic                            last_of_frame
);
  import tfd_pkg::*;

  localparam int LAYOUT_LEN = HEADER_LEN + DETECTORS + TIME_BYTES + WIN_BYTES
                              + CNT_BYTES * DETECTORS + RST_BYTES + UNUSED_LEN;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // frame state
  logic [POS_W-1:0]   byte_pos;
  logic [POS_W-1:0]   declared_size;
  logic [VALUE_W-1:0] acc;
  logic               size_short;

  layout_dec_t        dec;
  logic               advance;
  logic               end_hit;
  logic               res_fire;
  logic [VALUE_W-1:0] acc_shift;
  logic [POS_W:0]     pos_inc;

  tfd_layout #(
    .DETECTORS(DETECTORS)
  ) u_layout (
    .pos(byte_pos),
    .dec(dec)
  );

  assign advance    = in_valid && (!result_valid || !result_stall);
  assign data_stall = in_valid && !advance;

  assign pos_inc   = {1'b0, byte_pos} + (POS_W + 1)'(1);
  assign acc_shift = {acc[VALUE_W-9:0], in_byte};

  // frame end: layout end when size was short, else the declared last byte
  always_comb begin
    end_hit = 1'b0;
    if (byte_pos >= POS_W'(3)) begin
      if (size_short) begin
        end_hit = (byte_pos == POS_W'(LAYOUT_LEN - 1));
      end else begin
        end_hit = (declared_size != '0) && (pos_inc == {1'b0, declared_size});
      end
    end
  end

  assign res_fire = end_hit || (dec.hit && dec.done);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!data_stall) begin
      in_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      in_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos      <= '0;
      declared_size <= '0;
      acc           <= '0;
      size_short    <= 1'b0;
    end else if (advance) begin
      if (end_hit) begin
        byte_pos      <= '0;
        declared_size <= '0;
        acc           <= '0;
        size_short    <= 1'b0;
      end else begin
        byte_pos <= pos_inc[POS_W-1:0];
        if (dec.hit) begin
          acc <= dec.done ? '0 : acc_shift;
          if (dec.done && dec.kind == KIND_SIZE) begin
            declared_size <= acc_shift[POS_W-1:0];
            size_short    <= acc_shift[POS_W-1:0] < POS_W'(LAYOUT_LEN);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= res_fire;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      if (end_hit) begin
        field_kind     <= 4'(KIND_END);
        detector_index <= '0;
        field_value    <= '0;
        short_frame    <= size_short;
        last_of_frame  <= 1'b1;
      end else begin
        field_kind     <= 4'(dec.kind);
        detector_index <= dec.idx;
        if (dec.kind == KIND_COINC || dec.kind == KIND_TRIG) begin
          field_value <= VALUE_W'(in_byte == 8'd1);
        end else begin
          field_value <= acc_shift;
        end
        short_frame   <= 1'b0;
        last_of_frame <= 1'b0;
      end
    end
  end

  // frame end restarts the frame
  a_end_restart : assert property (@(posedge clk) disable iff (rst)
    advance && end_hit |=> byte_pos == '0 && !size_short)
    else $error("frame end did not clear frame state");

  a_short_bound : assert property (@(posedge clk) disable iff (rst)
    size_short |-> declared_size < POS_W'(LAYOUT_LEN))
    else $error("short flag set with a full-length size");

  a_short_on_end : assert property (@(posedge clk) disable iff (rst)
    result_valid && short_frame |-> last_of_frame)
    else $error("short flag outside frame end");

  a_last_kind : assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_frame |-> field_kind == 4'(KIND_END) && field_value == '0)
    else $error("frame end result malformed");

  a_index_kind : assert property (@(posedge clk) disable iff (rst)
    result_valid && detector_index != '0
      |-> field_kind == 4'(KIND_TRIG) || field_kind == 4'(KIND_COUNT))
    else $error("detector index on a non-detector field");

endmodule

`default_nettype wire
